[rtl/streaming_top_n_pixel_selector_unit_defines.svh]
// assertion macros for the top-n pixel selector
// used by the top level only; expects signals clk and rst_n in scope
`ifndef STREAMING_TOP_N_PIXEL_SELECTOR_UNIT_DEFINES_SVH
`define STREAMING_TOP_N_PIXEL_SELECTOR_UNIT_DEFINES_SVH

// property checked on every rising clk edge outside reset
`define TNPS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// implication checked in the next cycle
`define TNPS_ASSERT_NEXT(label, trig, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

[rtl/tnps_pkg.sv]
// shared types and constants for the top-n pixel selector
// no dependencies
package tnps_pkg;

    localparam int COORD_BITS = 12;
    localparam int VALUE_BITS = 16;
    localparam int KEEP_BITS  = 5;

    // one kept pixel
    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

    // input transfer payload
    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_x;
        logic [COORD_BITS-1:0] pixel_y;
        logic [VALUE_BITS-1:0] pixel_value;
        logic                  set_end;
    } in_item_t;

    // output transfer payload
    typedef struct packed {
        logic [COORD_BITS-1:0] out_x;
        logic [COORD_BITS-1:0] out_y;
        logic [VALUE_BITS-1:0] out_value;
        logic                  out_last;
    } out_item_t;

    // per-cycle command to every cell
    typedef struct packed {
        logic insert;   // candidate transfer this cycle
        logic shift;    // move chain one place toward cell 0
    } cell_ctrl_t;

    // controller states
    typedef enum logic [1:0] {
        ST_FILL  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage

[rtl/tnps_cell.sv]
// one cell of the sorted insertion chain
// depends on tnps_pkg
module tnps_cell
    import tnps_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic       enable,
    input  entry_t     cand,
    input  logic       left_ins,
    input  entry_t     left_data,
    input  logic       left_valid,
    input  entry_t     right_data,
    input  logic       right_valid,
    output logic       ins,
    output entry_t     data,
    output logic       valid
);

    logic   valid_reg;
    logic   valid_next;
    entry_t data_reg;
    entry_t data_next;

    // entries past the current limit count as empty
    assign valid = valid_reg & enable;
    assign data  = data_reg;

    // candidate belongs here or further left; equal values stay ahead
    assign ins = enable & (~valid | (cand.value > data_reg.value));

    // insert from the left, shift from the right, else hold
    always_comb
    begin
        valid_next = valid_reg;
        data_next  = data_reg;
        if (ctrl.insert)
        begin
            valid_next = valid;
            if (ins)
            begin
                if (left_ins)
                begin
                    valid_next = left_valid;
                    data_next  = left_data;
                end
                else
                begin
                    valid_next = 1'b1;
                    data_next  = cand;
                end
            end
        end
        else if (ctrl.shift)
        begin
            valid_next = right_valid;
            data_next  = right_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

[rtl/streaming_top_n_pixel_selector_unit.sv]
// top level of the streaming top-n pixel selector: cell chain and drain control
// depends on tnps_pkg, tnps_cell and the defines header
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+-----------
//  in       | input     | in_valid / in_ready  | in_item_t
//  out      | output    | out_valid / out_ready| out_item_t
//  cfg      | input     | cfg_we (no wait)     | keep_count
//
// every cell compares a candidate at once and the chain shifts right by one
// behind the insertion point; a new candidate is accepted while filling
// after a set_end transfer the chain shifts toward cell 0 once per result,
// so a set blocks input until its last kept pixel is loaded into the output register
// output stalls hold the chain; reset empties every cell, keep_count = 16
`include "streaming_top_n_pixel_selector_unit_defines.svh"

module streaming_top_n_pixel_selector_unit
    import tnps_pkg::*;
#(
    parameter int MAX_KEEP = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_we,
    input  logic [KEEP_BITS-1:0] cfg_wdata
);

    localparam int CNT_BITS = $clog2(MAX_KEEP + 1);
    localparam int LW       = (CNT_BITS > KEEP_BITS) ? CNT_BITS : KEEP_BITS;

    logic [KEEP_BITS-1:0] keep_count_reg;
    state_t               state_reg;
    state_t               state_next;
    logic                 out_valid_reg;
    out_item_t            out_reg;
    logic [LW-1:0]        kc_ext;
    logic [LW-1:0]        limit;
    logic                 in_fire;
    logic                 load;
    logic                 last_item;
    cell_ctrl_t           ctrl;
    entry_t               cand;

    entry_t               cell_data  [MAX_KEEP];
    logic [MAX_KEEP-1:0]  cell_valid;
    logic [MAX_KEEP-1:0]  cell_ins;
    logic [MAX_KEEP-1:0]  cell_en;

    // keep count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keep_count_reg <= KEEP_BITS'(16);
        end
        else if (cfg_we)
        begin
            keep_count_reg <= cfg_wdata;
        end
    end

    // effective limit: zero acts as one, saturate at chain length
    always_comb
    begin
        kc_ext = LW'(keep_count_reg);
        if (kc_ext == '0)
        begin
            limit = LW'(1);
        end
        else if (kc_ext > LW'(MAX_KEEP))
        begin
            limit = LW'(MAX_KEEP);
        end
        else
        begin
            limit = kc_ext;
        end
    end

    assign in_ready  = (state_reg == ST_FILL);
    assign in_fire   = in_valid & in_ready;
    assign load      = (state_reg == ST_DRAIN) & (~out_valid_reg | out_ready);
    assign ctrl      = '{insert: in_fire, shift: load};
    assign cand      = '{x: in_data.pixel_x, y: in_data.pixel_y, value: in_data.pixel_value};

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < MAX_KEEP; gi++)
        begin : g_cell
            logic   l_ins;
            logic   l_valid;
            entry_t l_data;
            logic   r_valid;
            entry_t r_data;

            assign cell_en[gi] = (LW'(gi) < limit);

            if (gi == 0)
            begin : g_head
                assign l_ins   = 1'b0;
                assign l_valid = 1'b0;
                assign l_data  = cand;
            end
            else
            begin : g_mid
                assign l_ins   = cell_ins[gi-1];
                assign l_valid = cell_valid[gi-1];
                assign l_data  = cell_data[gi-1];
            end

            if (gi == MAX_KEEP - 1)
            begin : g_tail
                assign r_valid = 1'b0;
                assign r_data  = cand;
            end
            else
            begin : g_body
                assign r_valid = cell_valid[gi+1];
                assign r_data  = cell_data[gi+1];
            end

            tnps_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .enable      (cell_en[gi]),
                .cand        (cand),
                .left_ins    (l_ins),
                .left_data   (l_data),
                .left_valid  (l_valid),
                .right_data  (r_data),
                .right_valid (r_valid),
                .ins         (cell_ins[gi]),
                .data        (cell_data[gi]),
                .valid       (cell_valid[gi])
            );
        end
    endgenerate

    // final result when nothing sits behind cell 0
    generate
        if (MAX_KEEP == 1)
        begin : g_last_one
            assign last_item = 1'b1;
        end
        else
        begin : g_last_many
            assign last_item = ~cell_valid[1];
        end
    endgenerate

    // fill / drain control
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (in_fire && in_data.set_end)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (load && last_item)
                begin
                    state_next = ST_FILL;
                end
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // output register, loaded from the head cell
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_reg <= '{out_x: cell_data[0].x, out_y: cell_data[0].y,
                         out_value: cell_data[0].value, out_last: last_item};
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // checks
    `TNPS_ASSERT(a_drain_head_valid, (state_reg == ST_DRAIN) |-> cell_valid[0], "drain with empty head cell")
    `TNPS_ASSERT(a_valid_prefix, ((cell_valid & (cell_valid + MAX_KEEP'(1))) == '0), "kept entries not contiguous from cell 0")
    `TNPS_ASSERT_NEXT(a_last_ends_drain, load && last_item, (state_reg == ST_FILL) && out_valid_reg && out_data.out_last, "final result did not end the drain")

endmodule
